// ===== rtl/x86e_pkg.sv =====
// Package: types, byte-sequence builder for the x86-64 instruction encoder.
package x86e_pkg;

  localparam int unsigned PositionWidthDefault = 32;
  localparam int unsigned MaxBytes = 10;
  localparam int unsigned CntW = 4;

  localparam logic [7:0] OpMovStore = 8'h89;
  localparam logic [7:0] OpMovLoad  = 8'h8B;
  localparam logic [7:0] OpTwoByte  = 8'h0F;
  localparam logic [7:0] OpGrp1Imm  = 8'h81;
  localparam logic [7:0] PfxF2      = 8'hF2;
  localparam logic [7:0] PfxF3      = 8'hF3;
  localparam logic [7:0] Pfx66      = 8'h66;
  localparam logic [7:0] RexB       = 8'h41;
  localparam logic [7:0] OpMovImm   = 8'hB8;
  localparam logic [7:0] OpSetcc    = 8'h90;
  localparam logic [7:0] OpJcc      = 8'h80;
  localparam logic [7:0] OpCall     = 8'hE8;
  localparam logic [7:0] SibRsp     = 8'h24;
  localparam logic [7:0] PfxNone    = 8'h00;

  // Request forms, numbered in encode order.
  typedef enum logic [6:0] {
    F_MOV_RR = 7'd0, F_MOV_RI64 = 7'd1, F_MOV_LOAD = 7'd2, F_MOV_STORE = 7'd3,
    F_STORE_SZ = 7'd4, F_LOAD_SZ = 7'd5, F_LEA_RIP = 7'd6, F_LOAD_RIP = 7'd7,
    F_STORE_RIP = 7'd8, F_ALU_RR = 7'd9, F_ALU_RI = 7'd10, F_IMUL = 7'd11,
    F_CQO = 7'd12, F_IDIV = 7'd13, F_DIV = 7'd14, F_NEG = 7'd15, F_NOT = 7'd16,
    F_SHIFT = 7'd17, F_SETCC = 7'd18, F_MOVZX8 = 7'd19, F_EXT_RR = 7'd20,
    F_PUSH = 7'd21, F_PUSH_IMM = 7'd22, F_POP = 7'd23, F_LEA_MEM = 7'd24,
    F_RET = 7'd25, F_LEAVE = 7'd26, F_CALL = 7'd27, F_JMP = 7'd28, F_JCC = 7'd29,
    F_SYSCALL = 7'd30, F_CLI = 7'd31, F_STI = 7'd32, F_HLT = 7'd33, F_IRETQ = 7'd34,
    F_SYSRETQ = 7'd35, F_IN_B = 7'd36, F_OUT_B = 7'd37, F_IN_W = 7'd38,
    F_OUT_W = 7'd39, F_LGDT = 7'd40, F_LIDT = 7'd41, F_INVLPG = 7'd42,
    F_LTR = 7'd43, F_WRMSR = 7'd44, F_RDMSR = 7'd45, F_MOV_FROM_CR = 7'd46,
    F_MOV_TO_CR = 7'd47, F_REP_STOSB = 7'd48, F_REP_MOVSB = 7'd49,
    F_MOVSD_XX = 7'd50, F_MOVSD_LD = 7'd51, F_MOVSD_ST = 7'd52, F_ADDSD = 7'd53,
    F_SUBSD = 7'd54, F_MULSD = 7'd55, F_DIVSD = 7'd56, F_UCOMISD = 7'd57,
    F_CVTSI2SD = 7'd58, F_CVTTSD2SI = 7'd59, F_MOVSS_XX = 7'd60,
    F_MOVSS_LD = 7'd61, F_MOVSS_ST = 7'd62, F_ADDSS = 7'd63, F_SUBSS = 7'd64,
    F_MULSS = 7'd65, F_DIVSS = 7'd66, F_UCOMISS = 7'd67, F_CVTSI2SS = 7'd68,
    F_CVTTSS2SI = 7'd69, F_CVTSD2SS = 7'd70, F_CVTSS2SD = 7'd71,
    F_MOVQ_TO_X = 7'd72, F_MOVQ_FROM_X = 7'd73
  } form_e;

  // ALU operations; unused codes behave as compare.
  typedef enum logic [2:0] {
    ALU_ADD = 3'd0, ALU_OR = 3'd1, ALU_AND = 3'd2, ALU_SUB = 3'd3,
    ALU_XOR = 3'd4, ALU_CMP = 3'd5
  } alu_e;

  typedef struct packed {
    logic [6:0]  req_type;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic signed [63:0] immediate;
    logic signed [31:0] displacement;
    logic [3:0]  access_size;
    logic        sign_extend;
    logic [2:0]  alu_op;
    logic [3:0]  cond_code;
    logic [2:0]  shift_kind;
    logic [3:0]  control_reg;
  } req_t;

  typedef struct packed {
    logic [7:0]  code_byte;
    logic [31:0] byte_position;
    logic        patch_site;
    logic        last_byte;
  } res_t;

  // One classified instruction: its bytes, count and patch marker.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          len;
    logic                     has_patch;
    logic [CntW-1:0]          patch_idx;
  } seq_t;

  function automatic logic [7:0] rex(logic w, logic [3:0] r, logic [3:0] b);
    return {4'h4, w, r[3], 1'b0, b[3]};
  endfunction

  function automatic logic [7:0] modrm(logic [1:0] md, logic [3:0] r, logic [3:0] m);
    return {md, r[2:0], m[2:0]};
  endfunction

  function automatic seq_t push_b(seq_t s, logic [7:0] v);
    seq_t t;
    t = s;
    t.bytes[s.len] = v;
    t.len = s.len + CntW'(1);
    return t;
  endfunction

  function automatic seq_t push32(seq_t s, logic [31:0] v);
    seq_t t;
    t = s;
    for (int i = 0; i < 4; i++) t = push_b(t, v[8*i +: 8]);
    return t;
  endfunction

  function automatic seq_t holder(seq_t s);
    seq_t t;
    t = s;
    t.has_patch = 1'b1;
    t.patch_idx = s.len;
    return push32(t, 32'h0);
  endfunction

  function automatic seq_t mem32(seq_t s, logic [3:0] r, logic [3:0] b, logic [31:0] d);
    seq_t t;
    t = push_b(s, modrm(2'd2, r, b));
    if (b[2:0] == 3'd4) t = push_b(t, SibRsp);
    return push32(t, d);
  endfunction

  function automatic seq_t two_rr(seq_t s, logic [7:0] pfx, logic w, logic [7:0] op,
                                  logic [3:0] r, logic [3:0] m);
    seq_t t;
    t = s;
    if (pfx != PfxNone) t = push_b(t, pfx);
    t = push_b(t, rex(w, r, m));
    t = push_b(t, OpTwoByte);
    t = push_b(t, op);
    return push_b(t, modrm(2'd3, r, m));
  endfunction

  function automatic seq_t sse_m(seq_t s, logic [7:0] pfx, logic [7:0] op,
                                 logic [3:0] r, logic [3:0] b, logic [31:0] d);
    seq_t t;
    t = push_b(s, pfx);
    t = push_b(t, rex(1'b0, r, b));
    t = push_b(t, OpTwoByte);
    t = push_b(t, op);
    return mem32(t, r, b, d);
  endfunction

  function automatic seq_t sys_m(seq_t s, logic [3:0] dg, logic [3:0] b);
    seq_t t;
    t = s;
    if (b[3]) t = push_b(t, RexB);
    t = push_b(t, OpTwoByte);
    t = push_b(t, 8'h01);
    if (b[2:0] == 3'd5) begin
      t = push_b(t, modrm(2'd1, dg, b));
      t = push_b(t, 8'h00);
    end else begin
      t = push_b(t, modrm(2'd0, dg, b));
      if (b[2:0] == 3'd4) t = push_b(t, SibRsp);
    end
    return t;
  endfunction

  function automatic seq_t f7(seq_t s, logic [3:0] dg, logic [3:0] r);
    seq_t t;
    t = push_b(s, rex(1'b1, 4'd0, r));
    t = push_b(t, 8'hF7);
    return push_b(t, modrm(2'd3, dg, r));
  endfunction

  function automatic seq_t rip(seq_t s, logic [7:0] op, logic [3:0] r);
    seq_t t;
    t = push_b(s, rex(1'b1, r, 4'd0));
    t = push_b(t, op);
    t = push_b(t, modrm(2'd0, r, 4'd5));
    return holder(t);
  endfunction

  function automatic seq_t encode(req_t q);
    seq_t t;
    logic [3:0] a, b;
    logic [31:0] d, i32;
    logic [2:0] op;
    logic [7:0] aluop;
    logic [3:0] dig;
    t = '0;
    a = q.reg_a; b = q.reg_b; d = q.displacement; i32 = q.immediate[31:0];
    op = q.alu_op;
    case (op)
      ALU_ADD: begin aluop = 8'h01; dig = 4'd0; end
      ALU_OR:  begin aluop = 8'h09; dig = 4'd1; end
      ALU_AND: begin aluop = 8'h21; dig = 4'd4; end
      ALU_SUB: begin aluop = 8'h29; dig = 4'd5; end
      ALU_XOR: begin aluop = 8'h31; dig = 4'd6; end
      default: begin aluop = 8'h39; dig = 4'd7; end
    endcase
    case (q.req_type)
      F_MOV_RR: begin t = push_b(t, rex(1'b1, b, a)); t = push_b(t, OpMovStore);
        t = push_b(t, modrm(2'd3, b, a)); end
      F_MOV_RI64: begin t = push_b(t, rex(1'b1, 4'd0, a));
        t = push_b(t, OpMovImm + {5'd0, a[2:0]});
        t = push32(t, q.immediate[31:0]); t = push32(t, q.immediate[63:32]); end
      F_MOV_LOAD: begin t = push_b(t, rex(1'b1, a, b)); t = push_b(t, OpMovLoad);
        t = mem32(t, a, b, d); end
      F_MOV_STORE: begin t = push_b(t, rex(1'b1, a, b)); t = push_b(t, OpMovStore);
        t = mem32(t, a, b, d); end
      F_STORE_SZ: begin
        if (q.access_size == 4'd1) begin t = push_b(t, rex(1'b0, a, b));
          t = push_b(t, 8'h88); end
        else if (q.access_size == 4'd2) begin t = push_b(t, Pfx66);
          t = push_b(t, rex(1'b0, a, b)); t = push_b(t, OpMovStore); end
        else if (q.access_size == 4'd4) begin t = push_b(t, rex(1'b0, a, b));
          t = push_b(t, OpMovStore); end
        else begin t = push_b(t, rex(1'b1, a, b)); t = push_b(t, OpMovStore); end
        t = mem32(t, a, b, d);
      end
      F_LOAD_SZ: begin
        if (q.access_size == 4'd1) begin t = push_b(t, rex(1'b1, a, b));
          t = push_b(t, OpTwoByte); t = push_b(t, q.sign_extend ? 8'hBE : 8'hB6); end
        else if (q.access_size == 4'd2) begin t = push_b(t, rex(1'b1, a, b));
          t = push_b(t, OpTwoByte); t = push_b(t, q.sign_extend ? 8'hBF : 8'hB7); end
        else if (q.access_size == 4'd4 && q.sign_extend) begin
          t = push_b(t, rex(1'b1, a, b)); t = push_b(t, 8'h63); end
        else if (q.access_size == 4'd4) begin t = push_b(t, rex(1'b0, a, b));
          t = push_b(t, OpMovLoad); end
        else begin t = push_b(t, rex(1'b1, a, b)); t = push_b(t, OpMovLoad); end
        t = mem32(t, a, b, d);
      end
      F_LEA_RIP: t = rip(t, 8'h8D, a);
      F_LOAD_RIP: t = rip(t, OpMovLoad, a);
      F_STORE_RIP: t = rip(t, OpMovStore, a);
      F_ALU_RR: begin t = push_b(t, rex(1'b1, b, a)); t = push_b(t, aluop);
        t = push_b(t, modrm(2'd3, b, a)); end
      F_ALU_RI: begin t = push_b(t, rex(1'b1, 4'd0, a)); t = push_b(t, OpGrp1Imm);
        t = push_b(t, modrm(2'd3, dig, a)); t = push32(t, i32); end
      F_IMUL: t = two_rr(t, PfxNone, 1'b1, 8'hAF, a, b);
      F_CQO: begin t = push_b(t, 8'h48); t = push_b(t, 8'h99); end
      F_IDIV: t = f7(t, 4'd7, a);
      F_DIV: t = f7(t, 4'd6, a);
      F_NEG: t = f7(t, 4'd3, a);
      F_NOT: t = f7(t, 4'd2, a);
      F_SHIFT: begin t = push_b(t, rex(1'b1, 4'd0, a)); t = push_b(t, 8'hD3);
        t = push_b(t, modrm(2'd3, {1'b0, q.shift_kind}, a)); end
      F_SETCC: t = two_rr(t, PfxNone, 1'b0, OpSetcc | {4'd0, q.cond_code}, 4'd0, a);
      F_MOVZX8: t = two_rr(t, PfxNone, 1'b1, 8'hB6, a, b);
      F_EXT_RR: begin
        if (q.access_size == 4'd1)
          t = two_rr(t, PfxNone, 1'b1, q.sign_extend ? 8'hBE : 8'hB6, a, b);
        else if (q.access_size == 4'd2)
          t = two_rr(t, PfxNone, 1'b1, q.sign_extend ? 8'hBF : 8'hB7, a, b);
        else if (q.access_size == 4'd4) begin
          if (q.sign_extend) begin t = push_b(t, rex(1'b1, a, b)); t = push_b(t, 8'h63); end
          else begin t = push_b(t, rex(1'b0, a, b)); t = push_b(t, OpMovLoad); end
          t = push_b(t, modrm(2'd3, a, b));
        end else if (a != b) begin
          t = push_b(t, rex(1'b1, b, a)); t = push_b(t, OpMovStore);
          t = push_b(t, modrm(2'd3, b, a));
        end
      end
      F_PUSH: begin if (a[3]) t = push_b(t, RexB); t = push_b(t, 8'h50 + {5'd0, a[2:0]}); end
      F_PUSH_IMM: begin t = push_b(t, 8'h68); t = push32(t, i32); end
      F_POP: begin if (a[3]) t = push_b(t, RexB); t = push_b(t, 8'h58 + {5'd0, a[2:0]}); end
      F_LEA_MEM: begin t = push_b(t, rex(1'b1, a, b)); t = push_b(t, 8'h8D);
        t = mem32(t, a, b, d); end
      F_RET: t = push_b(t, 8'hC3);
      F_LEAVE: t = push_b(t, 8'hC9);
      F_CALL: begin t = push_b(t, OpCall); t = holder(t); end
      F_JMP: begin t = push_b(t, 8'hE9); t = holder(t); end
      F_JCC: begin t = push_b(t, OpTwoByte); t = push_b(t, OpJcc | {4'd0, q.cond_code});
        t = holder(t); end
      F_SYSCALL: begin t = push_b(t, OpTwoByte); t = push_b(t, 8'h05); end
      F_CLI: t = push_b(t, 8'hFA);
      F_STI: t = push_b(t, 8'hFB);
      F_HLT: t = push_b(t, 8'hF4);
      F_IRETQ: begin t = push_b(t, 8'h48); t = push_b(t, 8'hCF); end
      F_SYSRETQ: begin t = push_b(t, 8'h48); t = push_b(t, OpTwoByte);
        t = push_b(t, 8'h07); end
      F_IN_B: t = push_b(t, 8'hEC);
      F_OUT_B: t = push_b(t, 8'hEE);
      F_IN_W: begin t = push_b(t, Pfx66); t = push_b(t, 8'hED); end
      F_OUT_W: begin t = push_b(t, Pfx66); t = push_b(t, 8'hEF); end
      F_LGDT: t = sys_m(t, 4'd2, b);
      F_LIDT: t = sys_m(t, 4'd3, b);
      F_INVLPG: t = sys_m(t, 4'd7, b);
      F_LTR: begin if (a[3]) t = push_b(t, RexB); t = push_b(t, OpTwoByte);
        t = push_b(t, 8'h00); t = push_b(t, modrm(2'd3, 4'd3, a)); end
      F_WRMSR: begin t = push_b(t, OpTwoByte); t = push_b(t, 8'h30); end
      F_RDMSR: begin t = push_b(t, OpTwoByte); t = push_b(t, 8'h32); end
      F_MOV_FROM_CR: t = two_rr(t, PfxNone, 1'b1, 8'h20, q.control_reg, a);
      F_MOV_TO_CR: t = two_rr(t, PfxNone, 1'b1, 8'h22, q.control_reg, b);
      F_REP_STOSB: begin t = push_b(t, PfxF3); t = push_b(t, 8'hAA); end
      F_REP_MOVSB: begin t = push_b(t, PfxF3); t = push_b(t, 8'hA4); end
      F_MOVSD_XX: t = two_rr(t, PfxF2, 1'b0, 8'h10, a, b);
      F_MOVSD_LD: t = sse_m(t, PfxF2, 8'h10, a, b, d);
      F_MOVSD_ST: t = sse_m(t, PfxF2, 8'h11, a, b, d);
      F_ADDSD: t = two_rr(t, PfxF2, 1'b0, 8'h58, a, b);
      F_SUBSD: t = two_rr(t, PfxF2, 1'b0, 8'h5C, a, b);
      F_MULSD: t = two_rr(t, PfxF2, 1'b0, 8'h59, a, b);
      F_DIVSD: t = two_rr(t, PfxF2, 1'b0, 8'h5E, a, b);
      F_UCOMISD: t = two_rr(t, Pfx66, 1'b0, 8'h2E, a, b);
      F_CVTSI2SD: t = two_rr(t, PfxF2, 1'b1, 8'h2A, a, b);
      F_CVTTSD2SI: t = two_rr(t, PfxF2, 1'b1, 8'h2C, a, b);
      F_MOVSS_XX: t = two_rr(t, PfxF3, 1'b0, 8'h10, a, b);
      F_MOVSS_LD: t = sse_m(t, PfxF3, 8'h10, a, b, d);
      F_MOVSS_ST: t = sse_m(t, PfxF3, 8'h11, a, b, d);
      F_ADDSS: t = two_rr(t, PfxF3, 1'b0, 8'h58, a, b);
      F_SUBSS: t = two_rr(t, PfxF3, 1'b0, 8'h5C, a, b);
      F_MULSS: t = two_rr(t, PfxF3, 1'b0, 8'h59, a, b);
      F_DIVSS: t = two_rr(t, PfxF3, 1'b0, 8'h5E, a, b);
      F_UCOMISS: t = two_rr(t, PfxNone, 1'b0, 8'h2E, a, b);
      F_CVTSI2SS: t = two_rr(t, PfxF3, 1'b1, 8'h2A, a, b);
      F_CVTTSS2SI: t = two_rr(t, PfxF3, 1'b1, 8'h2C, a, b);
      F_CVTSD2SS: t = two_rr(t, PfxF2, 1'b0, 8'h5A, a, b);
      F_CVTSS2SD: t = two_rr(t, PfxF3, 1'b0, 8'h5A, a, b);
      F_MOVQ_TO_X: t = two_rr(t, Pfx66, 1'b1, 8'h6E, a, b);
      F_MOVQ_FROM_X: t = two_rr(t, Pfx66, 1'b1, 8'h7E, b, a);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/x86_64_instruction_encoder_unit.sv =====
// Top level of the x86-64 instruction encoder.
//   channel | dir | handshake            | payload
//   request | in  | req_valid_i/req_stall_o | req_i (req_t)
//   result  | out | res_valid_o/res_stall_i | res_o (res_t), one byte each
// An instruction's bytes leave the byte serializer in order; the
// one-byte-per-cycle result port sets the rate while it is not stalled.
// Requests are encoded combinationally, registered, and wait in a two-entry
// queue; requests keep flowing while bytes drain. Byteless forms are dropped.
// Reset clears position counter, queue and valids. A result stall holds
// the output register; the queue absorbs requests until it is full.
module x86_64_instruction_encoder_unit #(
  parameter int unsigned PositionWidth = x86e_pkg::PositionWidthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_stall_o,
  input  x86e_pkg::req_t  req_i,
  output logic            res_valid_o,
  input  logic            res_stall_i,
  output x86e_pkg::res_t  res_o
);
  logic           push, full, qvld, pop;
  x86e_pkg::seq_t fseq, qseq;

  x86e_front u_front (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .req_i,
    .push_o(push), .seq_o(fseq), .full_i(full)
  );

  x86e_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .seq_i(fseq), .full_o(full),
    .vld_o(qvld), .seq_o(qseq), .pop_i(pop)
  );

  x86e_back #(.PositionWidth(PositionWidth)) u_back (
    .clk_i, .rst_ni, .vld_i(qvld), .seq_i(qseq), .pop_o(pop),
    .res_valid_o, .res_stall_i, .res_o
  );
endmodule

// ===== rtl/x86e_front.sv =====
// Front end: accepts requests, builds the byte sequence, registers it.
module x86e_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_stall_o,
  input  x86e_pkg::req_t  req_i,
  output logic            push_o,
  output x86e_pkg::seq_t  seq_o,
  input  logic            full_i
);
  logic           vld_q;
  x86e_pkg::seq_t seq_q;
  logic           take;
  x86e_pkg::seq_t enc;

  assign req_stall_o = vld_q && full_i;
  assign take  = req_valid_i && !req_stall_o;
  assign enc   = x86e_pkg::encode(req_i);
  assign push_o = vld_q && !full_i;
  assign seq_o  = seq_q;

  // empty sequences are dropped here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= (enc.len != '0);
    end else if (push_o) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      seq_q <= enc;
    end
  end
endmodule

// ===== rtl/x86e_queue.sv =====
// Two-entry queue of encoded sequences between front and back end.
module x86e_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  x86e_pkg::seq_t  seq_i,
  output logic            full_o,
  output logic            vld_o,
  output x86e_pkg::seq_t  seq_o,
  input  logic            pop_i
);
  x86e_pkg::seq_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o = cnt_q[1];
  assign vld_o  = cnt_q != 2'd0;
  assign seq_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= seq_i;
  end
endmodule

// ===== rtl/x86e_back.sv =====
// Back end: serializes one byte per unstalled cycle with running position.
module x86e_back #(
  parameter int unsigned PositionWidth = x86e_pkg::PositionWidthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  x86e_pkg::seq_t  seq_i,
  output logic            pop_o,
  output logic            res_valid_o,
  input  logic            res_stall_i,
  output x86e_pkg::res_t  res_o
);
  logic [x86e_pkg::CntW-1:0] idx_q;
  logic [PositionWidth-1:0]  pos_q;
  logic                      ov_q;
  x86e_pkg::res_t            res_q;
  logic                      load, fin;
  logic [31:0]               pos32;

  assign load = vld_i && (!ov_q || !res_stall_i);
  assign fin  = (idx_q + x86e_pkg::CntW'(1)) == seq_i.len;
  assign pop_o = load && fin;
  assign res_valid_o = ov_q;
  assign res_o = res_q;

  if (PositionWidth >= 32) begin : g_wide
    assign pos32 = pos_q[31:0];
  end else begin : g_narrow
    assign pos32 = 32'(pos_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; pos_q <= '0; ov_q <= 1'b0;
    end else begin
      if (load) begin
        ov_q  <= 1'b1;
        pos_q <= pos_q + PositionWidth'(1);
        idx_q <= fin ? '0 : idx_q + x86e_pkg::CntW'(1);
      end else if (!res_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q.code_byte     <= seq_i.bytes[idx_q];
      res_q.byte_position <= pos32;
      res_q.patch_site    <= seq_i.has_patch && (seq_i.patch_idx == idx_q);
      res_q.last_byte     <= fin;
    end
  end
endmodule

// ===== rtl/x86e_checker.sv =====
// Port-level checker for the encoder, bound to the top level.
module x86e_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           res_valid_o,
  input logic           res_stall_i,
  input x86e_pkg::res_t res_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(res_o)) else $error("stall hold");
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_stall_i ##1 res_valid_o |->
    res_o.byte_position == $past(res_o.byte_position) + 32'd1) else $error("position step");
  a_patch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.patch_site |-> res_o.code_byte == 8'h00) else $error("patch byte");
  a_patch_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.patch_site |-> !res_o.last_byte) else $error("patch last");
endmodule

bind x86_64_instruction_encoder_unit x86e_checker u_chk (
  .clk_i, .rst_ni, .res_valid_o, .res_stall_i, .res_o
);
